// ===== hw/rtl/u5p_pkg.sv =====
// ----------------------------------------------------------------------------
// u5p_pkg
// Shared widths, request codes and cigar operation codes for the unclipped
// 5-prime position core.
// ----------------------------------------------------------------------------
`default_nettype none

package u5p_pkg;

    // field widths
    localparam int OFFSET_W = 40;
    localparam int POS_W    = 31;
    localparam int LEN_W    = 28;
    localparam int INDEX_W  = 11;
    localparam int OP_W     = 4;
    localparam int COORD_W  = 64;

    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [OFFSET_W-1:0] t_offset;

    // request types
    localparam logic REQ_TABLE_WR = 1'b0;
    localparam logic REQ_CIGAR    = 1'b1;

    // cigar operation codes
    localparam logic [OP_W-1:0] OP_M    = 4'd0;
    localparam logic [OP_W-1:0] OP_D    = 4'd2;
    localparam logic [OP_W-1:0] OP_N    = 4'd3;
    localparam logic [OP_W-1:0] OP_SOFT = 4'd4;
    localparam logic [OP_W-1:0] OP_HARD = 4'd5;
    localparam logic [OP_W-1:0] OP_EQ   = 4'd7;
    localparam logic [OP_W-1:0] OP_X    = 4'd8;

endpackage

`default_nettype wire

// ===== hw/rtl/u5p_req_if.sv =====
// ----------------------------------------------------------------------------
// u5p_req_if
// Request channel: table writes and cigar elements, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface u5p_req_if;
    import u5p_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic signed [INDEX_W-1:0]  contig_index;
    logic [OFFSET_W-1:0]        offset_value;
    logic [POS_W-1:0]           start_pos;
    logic                       is_reverse;
    logic                       no_cigar;
    logic [OP_W-1:0]            cigar_op;
    logic [LEN_W-1:0]           cigar_len;
    logic                       first_element;
    logic                       last_element;

    modport source (
        output valid, req_type, contig_index, offset_value, start_pos, is_reverse,
               no_cigar, cigar_op, cigar_len, first_element, last_element,
        input  ready
    );

    modport sink (
        input  valid, req_type, contig_index, offset_value, start_pos, is_reverse,
               no_cigar, cigar_op, cigar_len, first_element, last_element,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/u5p_res_if.sv =====
// ----------------------------------------------------------------------------
// u5p_res_if
// Result channel: one unclipped 5-prime coordinate per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface u5p_res_if;
    import u5p_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] five_prime_coord;

    modport source (
        output valid, five_prime_coord,
        input  ready
    );

    modport sink (
        input  valid, five_prime_coord,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/unclipped_five_prime_position_core.sv =====
// ----------------------------------------------------------------------------
// unclipped_five_prime_position_core
// Contig offset table plus running cigar sums; gives the unclipped 5-prime
// coordinate of each read in unified coordinates.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_req     in   valid / ready    table write or one cigar element
//  o_res     out  valid / ready    five_prime_coord
//  i_cfg     in   i_cfg_wr_en      unmapped_coord (40 bit)
//
//  One item per cycle sustained while o_res is not stalled. After the edge that
//  accepts the last element (or no-cigar item), the result passes table read at
//  accept, then record update, partial sums and output register to o_res.valid.
//  The offset table is a single-port synchronous ram written at accept;
//  a read accepted after the write sees the new entry, so no forwarding is needed.
//  Synchronous active-low reset clears control and record state; the table
//  has no clearing pass and is undefined until written.
//  Stalls on o_res fill the bubbles first; i_req.ready drops only once the
//  element stage holds a result that cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module unclipped_five_prime_position_core #(
    parameter int MAX_CONTIGS = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire [u5p_pkg::OFFSET_W-1:0]  i_cfg_wr_data,
    u5p_req_if.sink                      i_req,
    u5p_res_if.source                    o_res
);
    import u5p_pkg::*;

    localparam int AW = (MAX_CONTIGS > 1) ? $clog2(MAX_CONTIGS) : 1;
    localparam logic [16:0] DEPTH = 17'(MAX_CONTIGS);

    // configuration register
    logic [OFFSET_W-1:0] r_unmapped;

    // offset table
    logic [OFFSET_W-1:0] mem [MAX_CONTIGS];
    logic [OFFSET_W-1:0] r_rd_data;

    // element stage
    logic             r_s1_valid;
    logic             r_s1_nocig;
    logic             r_s1_first;
    logic             r_s1_last;
    logic             r_s1_rev;
    logic             r_s1_neg;
    logic             r_s1_inrange;
    logic [OP_W-1:0]  r_s1_op;
    logic [LEN_W-1:0] r_s1_len;
    logic [POS_W-1:0] r_s1_pos;

    // record state
    t_coord r_base, r_lead, r_trail, r_ref;
    logic   r_in_lead;
    t_coord n_base, n_lead, n_trail, n_ref;
    logic   n_in_lead;

    // result stages
    logic   r_s2_valid, r_s2_rev;
    t_coord r_s2_base, r_s2_lead, r_s2_trail, r_s2_ref;
    t_coord n_s2_base, n_s2_lead, n_s2_trail, n_s2_ref;
    logic   n_s2_rev;
    logic   r_s3_valid, r_s3_rev;
    t_coord r_s3_fwd, r_s3_bm1, r_s3_rp;
    logic   r_o_valid;
    t_coord r_o_coord;

    logic             w_neg, w_inrange, w_acc, w_acc_elem, w_acc_wr;
    logic [16:0]      w_idx_u;
    logic [AW-1:0]    w_addr;
    logic             w_o_free, w_s3_free, w_s2_free, w_s1_res, w_s1_adv;
    t_coord           w_new_base, w_len;
    t_coord           w_e_base, w_e_lead, w_e_trail, w_e_ref;
    logic             w_e_in_lead;

    // index decode
    assign w_neg      = i_req.contig_index[INDEX_W-1];
    assign w_idx_u    = {7'b0, i_req.contig_index[INDEX_W-2:0]};
    assign w_inrange  = !w_neg && (w_idx_u < DEPTH);
    assign w_addr     = w_idx_u[AW-1:0];
    assign w_acc      = i_req.valid && i_req.ready;
    assign w_acc_elem = w_acc && (i_req.req_type == REQ_CIGAR);
    assign w_acc_wr   = w_acc && (i_req.req_type == REQ_TABLE_WR);

    // flow control
    assign w_o_free    = !r_o_valid || o_res.ready;
    assign w_s3_free   = !r_s3_valid || w_o_free;
    assign w_s2_free   = !r_s2_valid || w_s3_free;
    assign w_s1_res    = r_s1_nocig || r_s1_last;
    assign w_s1_adv    = r_s1_valid && (!w_s1_res || w_s2_free);
    assign i_req.ready = !r_s1_valid || w_s1_adv;

    assign o_res.valid            = r_o_valid;
    assign o_res.five_prime_coord = r_o_coord;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unmapped <= '0;
        end else if (i_cfg_wr_en) begin
            r_unmapped <= i_cfg_wr_data;
        end
    end

    // offset table write and read
    always_ff @(posedge i_clk) begin
        if (w_acc_wr && w_inrange) begin
            mem[w_addr] <= i_req.offset_value;
        end
        if (w_acc_elem && w_inrange) begin
            r_rd_data <= mem[w_addr];
        end
    end

    // element stage capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= w_acc_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_elem) begin
            r_s1_nocig   <= i_req.no_cigar;
            r_s1_first   <= i_req.first_element;
            r_s1_last    <= i_req.last_element;
            r_s1_rev     <= i_req.is_reverse;
            r_s1_neg     <= w_neg;
            r_s1_inrange <= w_inrange;
            r_s1_op      <= i_req.cigar_op;
            r_s1_len     <= i_req.cigar_len;
            r_s1_pos     <= i_req.start_pos;
        end
    end

    // base coordinate from table data
    always_comb begin
        if (r_s1_neg) begin
            w_new_base = COORD_W'(r_unmapped);
        end else if (r_s1_inrange) begin
            w_new_base = COORD_W'(r_rd_data) + COORD_W'(r_s1_pos);
        end else begin
            w_new_base = COORD_W'(r_s1_pos);
        end
    end

    // record update: first element restarts the sums
    always_comb begin
        w_len       = COORD_W'(r_s1_len);
        w_e_base    = r_s1_first ? w_new_base : r_base;
        w_e_lead    = r_s1_first ? '0 : r_lead;
        w_e_trail   = r_s1_first ? '0 : r_trail;
        w_e_ref     = r_s1_first ? '0 : r_ref;
        w_e_in_lead = r_s1_first ? 1'b1 : r_in_lead;

        n_lead    = w_e_lead;
        n_trail   = w_e_trail;
        n_ref     = w_e_ref;
        n_in_lead = w_e_in_lead;
        case (r_s1_op) inside
            OP_SOFT, OP_HARD: begin
                if (w_e_in_lead) begin
                    n_lead = w_e_lead + w_len;
                end
                n_trail = w_e_trail + w_len;
            end
            OP_M, OP_D, OP_N, OP_EQ, OP_X: begin
                n_in_lead = 1'b0;
                n_trail   = '0;
                n_ref     = w_e_ref + w_len;
            end
            default: begin
                n_in_lead = 1'b0;
                n_trail   = '0;
            end
        endcase
        n_base = w_e_base;

        // result operands
        if (r_s1_nocig) begin
            n_s2_base  = w_new_base;
            n_s2_lead  = '0;
            n_s2_trail = '0;
            n_s2_ref   = '0;
            n_s2_rev   = 1'b0;
        end else begin
            n_s2_base  = w_e_base;
            n_s2_lead  = n_lead;
            n_s2_trail = n_trail;
            n_s2_ref   = n_ref;
            n_s2_rev   = r_s1_rev;
        end
    end

    // record state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_lead    <= '0;
            r_trail   <= '0;
            r_ref     <= '0;
            r_in_lead <= 1'b1;
        end else if (w_s1_adv) begin
            if (w_s1_res) begin
                r_base    <= '0;
                r_lead    <= '0;
                r_trail   <= '0;
                r_ref     <= '0;
                r_in_lead <= 1'b1;
            end else begin
                r_base    <= n_base;
                r_lead    <= n_lead;
                r_trail   <= n_trail;
                r_ref     <= n_ref;
                r_in_lead <= n_in_lead;
            end
        end
    end

    // result pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_s2_free) begin
                r_s2_valid <= w_s1_adv && w_s1_res;
            end
            if (w_s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_o_free) begin
                r_o_valid <= r_s3_valid;
            end
        end
    end

    // result pipeline data
    always_ff @(posedge i_clk) begin
        if (w_s2_free && w_s1_adv && w_s1_res) begin
            r_s2_base  <= n_s2_base;
            r_s2_lead  <= n_s2_lead;
            r_s2_trail <= n_s2_trail;
            r_s2_ref   <= n_s2_ref;
            r_s2_rev   <= n_s2_rev;
        end
        if (w_s3_free && r_s2_valid) begin
            r_s3_fwd <= r_s2_base - r_s2_lead;
            r_s3_bm1 <= r_s2_base - COORD_W'(1);
            r_s3_rp  <= r_s2_ref + r_s2_trail;
            r_s3_rev <= r_s2_rev;
        end
        if (w_o_free && r_s3_valid) begin
            r_o_coord <= r_s3_rev ? (r_s3_bm1 + r_s3_rp) : r_s3_fwd;
        end
    end

`ifndef SYNTHESIS
    // record state is back at reset value after a result leaves the element stage
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_s1_res) |=> (r_base == '0 && r_lead == '0 && r_trail == '0 &&
                                    r_ref == '0 && r_in_lead))
        else $error("record state not cleared after result");

    // input is held off only while the element stage is occupied and blocked
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_s1_valid && w_s1_res && r_s2_valid && r_s3_valid && r_o_valid))
        else $error("input stalled with room in the pipeline");

    // a result stage fills only from an advancing result element
    a_s2_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_s2_valid) && r_s2_valid) |-> $past(w_s1_adv && w_s1_res))
        else $error("result stage filled without a result element");

    // a pending output is not overwritten while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_res.ready) |=> (r_o_valid && $stable(r_o_coord)))
        else $error("output lost while stalled");
`endif

endmodule

`default_nettype wire
